### rtl/amaf_pkg.sv
`timescale 1ns / 1ps
// Package for the adaptive moving average filter.
// Holds widths, register indexes, reset values, the sequencer states and the shared core config struct.
package amaf_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int SAMPLE_W   = 32;
    localparam int PERIOD_W   = 7;
    localparam int ALPHA_W    = 17;
    localparam int FILL_W     = ADDR_W + 1;
    localparam int ABS_W      = SAMPLE_W + 1;
    localparam int VSUM_W     = ABS_W + ADDR_W - 1;
    localparam int REM_W      = VSUM_W + 1;
    localparam int RATIO_W    = 17;
    localparam int MUL_W      = 18;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CNT_W-1:0]     DIV_LAST   = 5'd16;
    localparam logic [RATIO_W-1:0]   ONE_Q16    = 17'h10000;
    localparam logic [FILL_W-1:0]    FILL_FULL  = 7'(MAX_WINDOW);
    localparam logic [PERIOD_W-1:0]  PERIOD_MAX = 7'(MAX_WINDOW);
    localparam logic [PERIOD_W-1:0]  PERIOD_MIN = 7'd1;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW   = 2'd2;

    localparam logic [PERIOD_W-1:0]  PERIOD_RST = 7'd30;
    localparam logic [ALPHA_W-1:0]   FAST_RST   = 17'd43691;
    localparam logic [ALPHA_W-1:0]   SLOW_RST   = 17'd4228;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_SC_MUL,
        S_SC,
        S_SQ_MUL,
        S_SQ,
        S_LO_MUL,
        S_HI_MUL,
        S_SUM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [ALPHA_W-1:0]  fast;
        logic [ALPHA_W-1:0]  slow;
    } t_core_cfg;

endpackage

### rtl/amaf_window_ram.sv
`timescale 1ns / 1ps
// Sample window memory: one write port and one registered read port.
// Depends on amaf_pkg for depth and widths.
module amaf_window_ram
    import amaf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  logic [SAMPLE_W-1:0] i_wdata,
    input  logic                i_re,
    input  logic [ADDR_W-1:0]   i_raddr,
    output logic [SAMPLE_W-1:0] o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [MAX_WINDOW];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/amaf_mul.sv
`timescale 1ns / 1ps
// Shared signed 18 x 18 multiplier with a registered product.
// Depends on amaf_pkg for operand widths.
module amaf_mul
    import amaf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

### rtl/amaf_core.sv
`timescale 1ns / 1ps
// Sequencer and datapath: window scan, serial ratio divider and the multiply chain.
// Depends on amaf_pkg, amaf_window_ram and amaf_mul.
module amaf_core
    import amaf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_core_cfg           i_cfg,
    input  logic                i_restart,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [SAMPLE_W-1:0] o_res_avg
);

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_slot, n_slot;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                r_seeded, n_seeded;
    logic                r_pend, n_pend;
    logic [SAMPLE_W-1:0] r_prev, n_prev;
    logic [SAMPLE_W-1:0] r_x, n_x;
    logic [SAMPLE_W-1:0] r_last, n_last;
    logic [SAMPLE_W-1:0] r_avg, n_avg;
    logic [ADDR_W-1:0]   r_newest, n_newest;
    logic [FILL_W-1:0]   r_k, n_k;
    logic [VSUM_W-1:0]   r_vsum, n_vsum;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [RATIO_W-1:0]  r_q, n_q;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [RATIO_W-1:0]  r_sc, n_sc;
    logic [RATIO_W-1:0]  r_sc2, n_sc2;
    logic [RATIO_W-1:0]  r_frac, n_frac;
    logic [ABS_W-1:0]    r_d, n_d;

    logic                   wr_en;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [SAMPLE_W-1:0]    rd_data;
    logic                   mul_en;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic [SAMPLE_W-1:0] ad_a;
    logic [SAMPLE_W-1:0] ad_b;
    logic [ABS_W-1:0]    ad_diff;
    logic [ABS_W-1:0]    ad_abs;
    logic [FILL_W-1:0]   fill_inc;
    logic                rem_ge;
    logic [REM_W-1:0]    rem_sub;
    logic [20:0]         sc_sum;

    amaf_window_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_slot),
        .i_wdata (i_sample),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    amaf_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign ad_a     = r_pend ? r_last : r_x;
    assign ad_b     = r_pend ? rd_data : r_last;
    assign ad_diff  = {ad_a[SAMPLE_W-1], ad_a} - {ad_b[SAMPLE_W-1], ad_b};
    assign ad_abs   = ad_diff[ABS_W-1] ? (~ad_diff + 1'b1) : ad_diff;
    assign fill_inc = (r_fill == FILL_FULL) ? r_fill : r_fill + 1'b1;
    assign rem_sub  = r_rem - {1'b0, r_vsum};
    assign rem_ge   = r_rem >= {1'b0, r_vsum};
    assign sc_sum   = {4'b0, i_cfg.slow} + {mul_p[PROD_W-1], mul_p[PROD_W-1:16]};
    assign rd_addr  = r_newest - r_k[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_fill   <= '0;
            r_seeded <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_fill   <= n_fill;
            r_seeded <= n_seeded;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev   <= n_prev;
        r_x      <= n_x;
        r_last   <= n_last;
        r_avg    <= n_avg;
        r_newest <= n_newest;
        r_k      <= n_k;
        r_vsum   <= n_vsum;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_cnt    <= n_cnt;
        r_sc     <= n_sc;
        r_sc2    <= n_sc2;
        r_frac   <= n_frac;
        r_d      <= n_d;
    end

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_seeded    = r_seeded;
        n_pend      = r_pend;
        n_prev      = r_prev;
        n_x         = r_x;
        n_last      = r_last;
        n_avg       = r_avg;
        n_newest    = r_newest;
        n_k         = r_k;
        n_vsum      = r_vsum;
        n_rem       = r_rem;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_sc        = r_sc;
        n_sc2       = r_sc2;
        n_frac      = r_frac;
        n_d         = r_d;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        mul_en      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    wr_en    = 1'b1;
                    n_slot   = r_slot + 1'b1;
                    n_fill   = fill_inc;
                    n_x      = i_sample;
                    n_last   = i_sample;
                    n_newest = r_slot;
                    n_k      = FILL_W'(1);
                    n_pend   = 1'b0;
                    n_vsum   = '0;
                    n_d      = {i_sample[SAMPLE_W-1], i_sample} - {r_prev[SAMPLE_W-1], r_prev};
                    if (fill_inc < i_cfg.period) begin
                        n_state = S_IDLE;
                    end else if (!r_seeded) begin
                        n_seeded = 1'b1;
                        n_avg    = i_sample;
                        n_prev   = i_sample;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_en  = r_k < i_cfg.period;
                n_pend = rd_en;
                if (rd_en) begin
                    n_k = r_k + 1'b1;
                end
                if (r_pend) begin
                    n_vsum = r_vsum + {{(VSUM_W-ABS_W){1'b0}}, ad_abs};
                    n_last = rd_data;
                end else if (!rd_en) begin
                    n_rem = {{(REM_W-ABS_W){1'b0}}, ad_abs};
                    n_cnt = '0;
                    if (r_vsum == '0) begin
                        n_q     = ONE_Q16;
                        n_state = S_SC_MUL;
                    end else begin
                        n_q     = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem = rem_ge ? {rem_sub[REM_W-2:0], 1'b0} : {r_rem[REM_W-2:0], 1'b0};
                n_q   = {r_q[RATIO_W-2:0], rem_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_SC_MUL;
                end
            end
            S_SC_MUL: begin
                mul_en  = 1'b1;
                mul_a   = $signed({1'b0, r_q});
                mul_b   = $signed({1'b0, i_cfg.fast} - {1'b0, i_cfg.slow});
                n_state = S_SC;
            end
            S_SC: begin
                n_sc    = sc_sum[20] ? '0 : sc_sum[RATIO_W-1:0];
                n_state = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                mul_en  = 1'b1;
                mul_a   = $signed({1'b0, r_sc});
                mul_b   = $signed({1'b0, r_sc});
                n_state = S_SQ;
            end
            S_SQ: begin
                n_sc2   = mul_p[32:16];
                n_state = S_LO_MUL;
            end
            S_LO_MUL: begin
                mul_en  = 1'b1;
                mul_a   = $signed({2'b00, r_d[15:0]});
                mul_b   = $signed({1'b0, r_sc2});
                n_state = S_HI_MUL;
            end
            S_HI_MUL: begin
                n_frac  = mul_p[32:16];
                mul_en  = 1'b1;
                mul_a   = $signed({r_d[ABS_W-1], r_d[ABS_W-1:16]});
                mul_b   = $signed({1'b0, r_sc2});
                n_state = S_SUM;
            end
            S_SUM: begin
                n_avg   = r_prev + mul_p[SAMPLE_W-1:0] + {{(SAMPLE_W-RATIO_W){1'b0}}, r_frac};
                n_prev  = n_avg;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_avg = r_avg;

endmodule

### rtl/adaptive_moving_average_filter.sv
`timescale 1ns / 1ps
// Adaptive moving average filter top level: config registers, stream ports, output register.
// One item at a time: s_axis_tready is high only while the core is idle. An item gives no result
// until the window holds the effective period P of samples; the first result is the sample that
// fills it. Later ones take the scan, the serial divide (skipped for a flat window), the multiply
// chain and handoff; m_axis_tvalid rises with s_axis_tready; a full output stalls the core.
// Reset (i_rst_n low, synchronous) restores period 30 and both alphas, and empties the window.
module adaptive_moving_average_filter
    import amaf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [SAMPLE_W-1:0]   m_axis_tdata    // [31:0] average
);

    logic [PERIOD_W-1:0] r_period;
    logic [ALPHA_W-1:0]  r_fast;
    logic [ALPHA_W-1:0]  r_slow;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;

    t_core_cfg           core_cfg;
    logic                restart;
    logic                core_res_valid;
    logic                core_res_ready;
    logic [SAMPLE_W-1:0] core_avg;

    assign restart = i_cfg_we && (i_cfg_index == REG_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_fast   <= FAST_RST;
            r_slow   <= SLOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                REG_FAST:   r_fast   <= i_cfg_data[ALPHA_W-1:0];
                REG_SLOW:   r_slow   <= i_cfg_data[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_period == '0) begin
            core_cfg.period = PERIOD_MIN;
        end else if (r_period > PERIOD_MAX) begin
            core_cfg.period = PERIOD_MAX;
        end else begin
            core_cfg.period = r_period;
        end
        core_cfg.fast = (r_fast > ONE_Q16) ? ONE_Q16 : r_fast;
        core_cfg.slow = (r_slow > ONE_Q16) ? ONE_Q16 : r_slow;
    end

    amaf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (core_cfg),
        .i_restart   (restart),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_sample    (s_axis_tdata),
        .o_res_valid (core_res_valid),
        .i_res_ready (core_res_ready),
        .o_res_avg   (core_avg)
    );

    assign core_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res_ready) begin
            r_out_valid <= core_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res_valid && core_res_ready) begin
            r_out_data <= core_avg;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_res_valid && !core_res_ready && !restart) |=>
            (core_res_valid && $stable(core_avg)))
        else $error("core result changed while waiting for the output register");

    a_res_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_res_valid && core_res_ready) |=> m_axis_tvalid)
        else $error("handed-over result did not reach the output register");

    a_restart_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> (s_axis_tready && !core_res_valid))
        else $error("period write did not return the sequencer to idle");
`endif

endmodule
